// ===== rtl/adm_pkg.sv =====
// ----------------------------------------------------------------------------
// adm_pkg: shared types and constants of the arcade drive mixer
// Field widths, register codes and reset values, and the structs that run
// between the top level, the sequencer and the divider.
// ----------------------------------------------------------------------------
package adm_pkg;

   // Field and datapath widths
   localparam int AXIS_W   = 8;   // joystick axis, signed
   localparam int MAG_W    = 7;   // axis magnitude after range check
   localparam int DZ_W     = 7;   // deadzone register
   localparam int GAIN_W   = 4;   // axis gain register
   localparam int BLEND_W  = 16;  // Q16 blend weight
   localparam int SPEED_W  = 12;  // reported speed, signed
   localparam int FRAC_W   = 16;  // fraction bits of a level
   localparam int LEVEL_W  = 28;  // Q12.16 level, signed
   localparam int GAP_W    = LEVEL_W + 1;
   localparam int MUL_A_W  = GAP_W;          // signed multiplier operand A
   localparam int MUL_B_W  = BLEND_W + 1;    // signed multiplier operand B
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int NUM_W    = 26;  // signed shaped sum, also dividend width
   localparam int DEN_W    = 15;  // 100 * (|x| + |y|) <= 20000
   localparam int QUO_W    = 11;  // quotient magnitude <= 1500
   localparam int CNT_W    = $clog2(QUO_W + 1);
   localparam int TOTAL_W  = 8;   // |x| + |y| <= 200
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int AXIS_LIMIT = 100;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEADZONE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_GAIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_BLEND  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_BLEND = 2'd3;

   // Register reset values
   localparam logic [DZ_W-1:0]    DEADZONE_RST    = 7'd5;
   localparam logic [GAIN_W-1:0]  AXIS_GAIN_RST   = 4'd6;
   localparam logic [BLEND_W-1:0] LEFT_BLEND_RST  = 16'd6554;
   localparam logic [BLEND_W-1:0] RIGHT_BLEND_RST = 16'd3277;

   // Configuration as seen by the sequencer
   typedef struct packed {
      logic [DZ_W-1:0]    deadzone;
      logic [GAIN_W-1:0]  axis_gain;
      logic [BLEND_W-1:0] left_blend;
      logic [BLEND_W-1:0] right_blend;
   } cfg_type;

   // One result item
   typedef struct packed {
      logic signed [SPEED_W-1:0] left_speed;
      logic signed [SPEED_W-1:0] right_speed;
      logic                      brake;
   } result_type;

   // Divider request
   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

endpackage

// ===== rtl/adm_div.sv =====
// ----------------------------------------------------------------------------
// adm_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle. The caller guarantees the
// quotient fits QUO_W bits, so only QUO_W steps are run.
// ----------------------------------------------------------------------------
module adm_div
   import adm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_req_type       req,
   output logic              done,
   output logic [QUO_W-1:0]  quotient
);

   logic [NUM_W-1:0] rem_ff;
   logic [NUM_W-1:0] dsh_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic             fit;
   logic [NUM_W-1:0] rem_in;

   // compare and subtract against the shifted divisor
   assign fit    = (rem_ff >= dsh_ff);
   assign rem_in = fit ? (rem_ff - dsh_ff) : rem_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QUO_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= req.dividend;
         dsh_ff <= NUM_W'(req.divisor) << (QUO_W - 1);
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dsh_ff <= dsh_ff >> 1;
         quo_ff <= {quo_ff[QUO_W-2:0], fit};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/adm_core.sv =====
// ----------------------------------------------------------------------------
// adm_core: mixer sequencer with one shared multiplier
// Range and deadzone checks, cubic shaping, two divisions and the Q16 blend
// of both side levels, all stepped through one 29x17 multiplier and the
// iterative divider.
// ----------------------------------------------------------------------------
module adm_core
   import adm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      start,
   input  logic                      kind,
   input  logic signed [AXIS_W-1:0]  joy_x,
   input  logic signed [AXIS_W-1:0]  joy_y,
   output logic                      idle,
   output logic                      res_valid,
   input  logic                      res_ready,
   output result_type                res
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_BLEND,
      ST_EMIT
   } state_type;

   // multiply schedule steps
   localparam logic [2:0] STEP_X1 = 3'd0;  // x * |x|
   localparam logic [2:0] STEP_X2 = 3'd1;  // * |x|
   localparam logic [2:0] STEP_XG = 3'd2;  // * gain
   localparam logic [2:0] STEP_Y1 = 3'd3;  // y * |y|, sx ready
   localparam logic [2:0] STEP_Y2 = 3'd4;
   localparam logic [2:0] STEP_YG = 3'd5;
   localparam logic [2:0] STEP_DN = 3'd6;  // 100 * total, sy ready
   // blend schedule steps
   localparam logic [2:0] STEP_BL = 3'd0;
   localparam logic [2:0] STEP_BR = 3'd1;
   localparam logic [2:0] STEP_BU = 3'd2;

   state_type                  state_ff;
   logic [2:0]                 step_ff;
   logic                       side_ff;
   logic signed [AXIS_W-1:0]   x_ff;
   logic signed [AXIS_W-1:0]   y_ff;
   logic [MAG_W-1:0]           ax_ff;
   logic [MAG_W-1:0]           ay_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [NUM_W-1:0]    sx_ff;
   logic signed [NUM_W-1:0]    sy_ff;
   logic [DEN_W-1:0]           den_ff;
   logic signed [SPEED_W-1:0]  lt_ff;
   logic signed [SPEED_W-1:0]  rt_ff;
   logic signed [LEVEL_W-1:0]  left_level_ff;
   logic signed [LEVEL_W-1:0]  right_level_ff;
   logic                       brake_ff;

   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic signed [GAP_W-1:0]    gap_l;
   logic signed [GAP_W-1:0]    gap_r;
   logic signed [NUM_W-1:0]    num_sum;
   logic signed [NUM_W-1:0]    num_dif;
   logic [NUM_W-1:0]           mag_sum;
   logic [NUM_W-1:0]           mag_dif;
   logic [AXIS_W-1:0]          ax_raw;
   logic [AXIS_W-1:0]          ay_raw;
   logic                       x_dead;
   logic                       y_dead;
   logic [TOTAL_W-1:0]         total;
   logic signed [LEVEL_W-1:0]  level_inc;
   logic [SPEED_W-1:0]         quo_ext;
   logic signed [SPEED_W-1:0]  quo_signed;
   logic                       quo_neg;
   div_req_type                div_req;
   logic                       div_done;
   logic [QUO_W-1:0]           div_quo;

   // axis magnitudes and deadzone
   assign ax_raw = x_ff[AXIS_W-1] ? AXIS_W'(-x_ff) : AXIS_W'(x_ff);
   assign ay_raw = y_ff[AXIS_W-1] ? AXIS_W'(-y_ff) : AXIS_W'(y_ff);
   assign x_dead = ({1'b0, ax_raw} < {2'b00, cfg.deadzone});
   assign y_dead = ({1'b0, ay_raw} < {2'b00, cfg.deadzone});
   assign total  = TOTAL_W'(ax_ff) + TOTAL_W'(ay_ff);

   // gap between target and level, target in Q16 (sign-extended)
   assign gap_l = GAP_W'($signed({lt_ff, {FRAC_W{1'b0}}})) - GAP_W'(left_level_ff);
   assign gap_r = GAP_W'($signed({rt_ff, {FRAC_W{1'b0}}})) - GAP_W'(right_level_ff);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_MUL) begin
         case (step_ff)
            STEP_X1: begin
               mul_a = MUL_A_W'(x_ff);
               mul_b = MUL_B_W'(ax_ff);
            end
            STEP_X2, STEP_Y2: begin
               mul_a = prod_ff[MUL_A_W-1:0];
               mul_b = MUL_B_W'((step_ff == STEP_X2) ? ax_ff : ay_ff);
            end
            STEP_XG, STEP_YG: begin
               mul_a = prod_ff[MUL_A_W-1:0];
               mul_b = MUL_B_W'(cfg.axis_gain);
            end
            STEP_Y1: begin
               mul_a = MUL_A_W'(y_ff);
               mul_b = MUL_B_W'(ay_ff);
            end
            STEP_DN: begin
               mul_a = MUL_A_W'(total);
               mul_b = MUL_B_W'(AXIS_LIMIT);
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end else if (state_ff == ST_BLEND) begin
         if (step_ff == STEP_BL) begin
            mul_a = gap_l;
            mul_b = MUL_B_W'(cfg.left_blend);
         end else if (step_ff == STEP_BR) begin
            mul_a = gap_r;
            mul_b = MUL_B_W'(cfg.right_blend);
         end
      end
   end

   assign mul_p = mul_a * mul_b;

   // floor of the blended product by 2^16
   assign level_inc = prod_ff[FRAC_W+LEVEL_W-1:FRAC_W];

   // numerators and their magnitudes
   assign num_sum = sx_ff + sy_ff;
   assign num_dif = sx_ff - sy_ff;
   assign mag_sum = num_sum[NUM_W-1] ? NUM_W'(-num_sum) : NUM_W'(num_sum);
   assign mag_dif = num_dif[NUM_W-1] ? NUM_W'(-num_dif) : NUM_W'(num_dif);

   // divider requests: left at load, right when the left one is done
   always_comb begin
      div_req.start    = (state_ff == ST_LOAD) ||
                         (state_ff == ST_DIV && div_done && !side_ff);
      div_req.dividend = (state_ff == ST_LOAD) ? mag_sum : mag_dif;
      div_req.divisor  = (state_ff == ST_LOAD) ? prod_ff[DEN_W-1:0] : den_ff;
   end

   adm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   // quotient truncated toward zero
   assign quo_neg    = side_ff ? num_dif[NUM_W-1] : num_sum[NUM_W-1];
   assign quo_ext    = SPEED_W'(div_quo);
   assign quo_signed = quo_neg ? -$signed(quo_ext) : $signed(quo_ext);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         side_ff        <= 1'b0;
         left_level_ff  <= '0;
         right_level_ff <= '0;
         brake_ff       <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  if (kind) begin
                     left_level_ff  <= '0;
                     right_level_ff <= '0;
                     brake_ff       <= 1'b1;
                     state_ff       <= ST_EMIT;
                  end else begin
                     x_ff     <= joy_x;
                     y_ff     <= joy_y;
                     brake_ff <= 1'b0;
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               if (ax_raw > AXIS_W'(AXIS_LIMIT) || ay_raw > AXIS_W'(AXIS_LIMIT)) begin
                  state_ff <= ST_IDLE;
               end else if (x_dead && y_dead) begin
                  state_ff <= ST_IDLE;
               end else begin
                  x_ff     <= x_dead ? '0 : x_ff;
                  y_ff     <= y_dead ? '0 : y_ff;
                  ax_ff    <= x_dead ? '0 : ax_raw[MAG_W-1:0];
                  ay_ff    <= y_dead ? '0 : ay_raw[MAG_W-1:0];
                  step_ff  <= STEP_X1;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff <= mul_p;
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_Y1) begin
                  sx_ff <= prod_ff[NUM_W-1:0];
               end
               if (step_ff == STEP_DN) begin
                  sy_ff    <= prod_ff[NUM_W-1:0];
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               den_ff   <= prod_ff[DEN_W-1:0];
               side_ff  <= 1'b0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  if (!side_ff) begin
                     lt_ff   <= quo_signed;
                     side_ff <= 1'b1;
                  end else begin
                     rt_ff    <= quo_signed;
                     step_ff  <= STEP_BL;
                     state_ff <= ST_BLEND;
                  end
               end
            end
            ST_BLEND: begin
               prod_ff <= mul_p;
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_BR) begin
                  left_level_ff <= left_level_ff + level_inc;
               end
               if (step_ff == STEP_BU) begin
                  right_level_ff <= right_level_ff + level_inc;
                  state_ff       <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (res_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // integer part of each level, truncated toward zero
   always_comb begin
      res.left_speed  = left_level_ff[LEVEL_W-1:FRAC_W] +
                        SPEED_W'(left_level_ff[LEVEL_W-1] && (|left_level_ff[FRAC_W-1:0]));
      res.right_speed = right_level_ff[LEVEL_W-1:FRAC_W] +
                        SPEED_W'(right_level_ff[LEVEL_W-1] && (|right_level_ff[FRAC_W-1:0]));
      res.brake       = brake_ff;
   end

   assign res_valid = (state_ff == ST_EMIT);
   assign idle      = (state_ff == ST_IDLE);

endmodule

// ===== rtl/arcade_drive_mixer_smoothed.sv =====
// ----------------------------------------------------------------------------
// arcade_drive_mixer_smoothed: arcade drive mixer with deadzone and smoothing
// Mixes a turn and a forward axis into smoothed left and right speeds.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_* (valid/ready): req_kind 0 is a drive request with
//   req_joy_x / req_joy_y, req_kind 1 is a stop that clears both levels and
//   returns zero speeds with rsp_brake set.
//   A drive request with an axis beyond +-100, or with both axes inside the
//   deadzone, gives no response and leaves the levels untouched.
//   Responses leave on rsp_* (valid/ready) from an output register.
//   Registers are written on csr_* (always ready); write only while idle.
//   Flow: one request at a time. A drive request passes through the
//   range check, seven multiply steps on the shared multiplier, the
//   divisor load, two 11-step divisions, three blend steps and the move
//   into the output register; a stop request skips all but the move into
//   the output register. The next request is taken in the cycle after the
//   response enters the output register; a stalled receiver holds the
//   sequencer in its last step.
//   Reset: levels clear to zero, registers return to deadzone 5, gain 6,
//   left blend 6554 and right blend 3277; no response is pending.
// ----------------------------------------------------------------------------
module arcade_drive_mixer_smoothed
   import adm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic signed [AXIS_W-1:0]      req_joy_x,
   input  logic signed [AXIS_W-1:0]      req_joy_y,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SPEED_W-1:0]     rsp_left_speed,
   output logic signed [SPEED_W-1:0]     rsp_right_speed,
   output logic                          rsp_brake,
   // register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   cfg_type    cfg_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;

   logic       core_idle;
   logic       res_valid;
   logic       res_ready;
   result_type res;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadzone    <= DEADZONE_RST;
         cfg_ff.axis_gain   <= AXIS_GAIN_RST;
         cfg_ff.left_blend  <= LEFT_BLEND_RST;
         cfg_ff.right_blend <= RIGHT_BLEND_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DEADZONE:    cfg_ff.deadzone    <= csr_wdata[DZ_W-1:0];
            CSR_AXIS_GAIN:   cfg_ff.axis_gain   <= csr_wdata[GAIN_W-1:0];
            CSR_LEFT_BLEND:  cfg_ff.left_blend  <= csr_wdata[BLEND_W-1:0];
            CSR_RIGHT_BLEND: cfg_ff.right_blend <= csr_wdata[BLEND_W-1:0];
            default:         cfg_ff             <= cfg_ff;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   adm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .start     (req_valid && core_idle),
      .kind      (req_kind),
      .joy_x     (req_joy_x),
      .joy_y     (req_joy_y),
      .idle      (core_idle),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign req_ready = core_idle;

   // output register
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_speed  = rsp_ff.left_speed;
   assign rsp_right_speed = rsp_ff.right_speed;
   assign rsp_brake       = rsp_ff.brake;

endmodule
